// ===== rtl/esi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esi_pkg - shared types and constants of the extended Simpson integrator
// Payload structs, state encodings, scaling constants and the end-weight table.
// ----------------------------------------------------------------------------
package esi_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int STEP_W     = 32;
    localparam int INTEG_W    = 64;
    localparam int POINTS_W   = 17;

    // configuration port
    localparam int                    PADDR_W            = 3;
    localparam int                    PDATA_W            = 32;
    localparam logic                  REG_IDX_STEP_SIZE  = 1'b0;

    // end-correction sequence
    localparam int                    END_POINTS    = 4;
    localparam int                    COEF_W        = 7;
    localparam int                    CPROD_W       = COEF_W + SAMPLE_W;
    localparam logic [3:0]            WSUM_LAST     = 4'd9;
    localparam int                    LONG_RUN_MIN  = 8;
    localparam int                    SHORT_RUN_MIN = 2;

    // scaling: |w| * |step| / (3 * 2^20), round half up
    localparam int                    MAG_W       = 64;
    localparam int                    LIMB_W      = 32;
    localparam int                    PROD_W      = MAG_W + STEP_W;
    localparam int                    FRAC_SHIFT  = 20;
    localparam int                    DIV_W       = PROD_W - FRAC_SHIFT;
    localparam logic [PROD_W-1:0]     ROUND_BIAS  = PROD_W'(1572864);
    localparam logic [1:0]            DIVISOR     = 2'd3;

    // divide by 3 one 16-bit digit per cycle: q = (cur * RECIP_3) >> 19,
    // exact for cur < 3 * 2^16
    localparam int                    DIGIT_W     = 16;
    localparam int                    DIV_DIGITS  = (DIV_W + DIGIT_W - 1) / DIGIT_W;
    localparam int                    QUO_W       = DIGIT_W * DIV_DIGITS;
    localparam int                    CUR_W       = DIGIT_W + 2;
    localparam int                    RECIP_W     = 18;
    localparam int                    RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0]    RECIP_3     = 18'd174763;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in_item;

    typedef struct packed {
        logic signed [INTEG_W-1:0]  integral;
        logic                       saturated;
        logic                       count_overflow;
        logic [POINTS_W-1:0]        points_used;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WSUM,
        ST_START,
        ST_WAIT,
        ST_FINISH
    } t_esi_state;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL_LO,
        SC_MUL_HI,
        SC_ACC,
        SC_DIV,
        SC_SAT
    } t_sc_state;

    typedef struct packed {
        logic                       start;
        logic signed [MAG_W-1:0]    wsum;
        logic signed [STEP_W-1:0]   step;
    } t_sc_req;

    typedef struct packed {
        logic                       done;
        logic                       sat;
        logic signed [INTEG_W-1:0]  value;
    } t_sc_rsp;

    // weight correction (times 48) for the k-th sample from either end
    function automatic logic signed [COEF_W-1:0] end_coef(
        input logic [1:0] k,
        input logic       long_run,
        input logic       short_run
    );
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (long_run) begin
            case (k)
                2'd0:    c = -7'sd31;
                2'd1:    c = 7'sd11;
                2'd2:    c = -7'sd5;
                2'd3:    c = 7'sd1;
                default: c = '0;
            endcase
        end else if (short_run && (k == 2'd0)) begin
            c = -7'sd24;
        end
        return c;
    endfunction

endpackage

// ===== rtl/extended_simpson_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_simpson_integrator - streaming integral of equally spaced samples
// Accumulates Q16.16 samples and emits the extended Simpson integral of a run.
// ----------------------------------------------------------------------------
// A sample word without the last flag is accepted whenever the block is
// idle: it is added to the running sum and kept in the head or tail window.
// A word with last set starts the end-of-run pass and the input stays not
// ready until the result is loaded into the output register: end
// corrections through one shared adder, a low and a high 32x32 multiply
// pass and a product accumulate, divide by 3 at one 16-bit digit per
// cycle, plus the sequencing steps (start, saturate, done, load); the load
// waits while a previous result still sits unread in the output register.
// Samples of the next run are accepted while a finished result waits
// downstream. Runs of eight points or more get the extended Simpson end
// weights, runs of two to seven trapezoid ends. Runs longer than MAX_POINTS
// drop the extra samples and flag count_overflow. The result is the weighted
// sum times step_size, rounded half away from zero, saturated to 64 bits.
// step_size sits at byte address 0 of the APB port and resets to 1.0.
// ----------------------------------------------------------------------------
module extended_simpson_integrator #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [esi_pkg::PADDR_W-1:0]  paddr,
    input  logic [esi_pkg::PDATA_W-1:0]  pwdata,
    output logic [esi_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    // sample words
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  esi_pkg::t_in_item            i_in_data,
    // result words
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output esi_pkg::t_out_item           o_out_data
);
    import esi_pkg::*;

    // count holds 0..MAX_POINTS; sum of MAX_POINTS 32-bit samples
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = SAMPLE_W + $clog2(MAX_POINTS);
    // 48 * sum plus end corrections
    localparam int WW = SW + 7;
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_POINTS);
    localparam logic [CW-1:0] END_CNT   = CW'(END_POINTS);
    localparam logic [CW-1:0] LONG_CNT  = CW'(LONG_RUN_MIN);
    localparam logic [CW-1:0] SHORT_CNT = CW'(SHORT_RUN_MIN);

    t_esi_state                 r_state, n_state;
    logic signed [STEP_W-1:0]   r_step_size;
    logic signed [SW-1:0]       r_sum;
    logic [CW-1:0]              r_count;
    logic                       r_ovf;
    logic signed [SAMPLE_W-1:0] r_head [END_POINTS];
    logic signed [SAMPLE_W-1:0] r_tail [END_POINTS];   // entry 0 newest
    logic [3:0]                 r_wstep;
    logic signed [WW-1:0]       r_acc;
    logic                       r_out_valid;
    t_out_item                  r_out_data;

    logic                       in_fire;
    logic                       take_sample;
    logic                       cfg_wr;
    logic                       sc_start;
    logic                       out_load;
    t_sc_req                    sc_req;
    t_sc_rsp                    sc_rsp;

    // end-correction operand
    logic [2:0]                 wsel;
    logic                       long_run, short_run;
    logic signed [COEF_W-1:0]   coef;
    logic signed [SAMPLE_W-1:0] corr_sample;
    logic signed [CPROD_W-1:0]  corr_prod, corr_sel;
    logic signed [WW-1:0]       sum_ext, operand, acc_base;

    assign in_fire     = i_in_valid && o_in_ready;
    assign take_sample = in_fire && (r_count < MAX_CNT);
    assign cfg_wr      = psel && penable && pwrite && pready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_fire && i_in_data.last) n_state = ST_WSUM;
            ST_WSUM:   if (r_wstep == WSUM_LAST) n_state = ST_START;
            ST_START:  n_state = ST_WAIT;
            ST_WAIT:   if (sc_rsp.done) n_state = ST_FINISH;
            ST_FINISH: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        sc_start   = (r_state == ST_START);
        out_load   = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
    end

    // shared adder operand: steps 0/1 build 48*sum as 32*sum + 16*sum,
    // steps 2..9 walk head/tail pairs k = 0..3
    always_comb begin
        wsel        = 3'(r_wstep - 4'd2);
        long_run    = (r_count >= LONG_CNT);
        short_run   = (r_count >= SHORT_CNT) && !long_run;
        coef        = end_coef(wsel[2:1], long_run, short_run);
        corr_sample = wsel[0] ? r_tail[wsel[2:1]] : r_head[wsel[2:1]];
        corr_prod   = coef * corr_sample;
        // zero weight must not read a window entry that was never filled
        corr_sel    = (coef != '0) ? corr_prod : '0;
        sum_ext     = {{(WW-SW){r_sum[SW-1]}}, r_sum};
        case (r_wstep)
            4'd0:    operand = sum_ext <<< 5;
            4'd1:    operand = sum_ext <<< 4;
            default: operand = {{(WW-CPROD_W){corr_sel[CPROD_W-1]}}, corr_sel};
        endcase
        acc_base = (r_wstep == 4'd0) ? '0 : r_acc;
    end

    // control and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step_size <= STEP_W'(65536);
            r_sum       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_wstep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_wr && (paddr[PADDR_W-1] == REG_IDX_STEP_SIZE)) begin
                r_step_size <= pwdata;
            end

            if (take_sample) begin
                r_sum   <= r_sum + {{(SW-SAMPLE_W){i_in_data.sample[SAMPLE_W-1]}},
                                    i_in_data.sample};
                r_count <= r_count + 1'b1;
            end else if (in_fire) begin
                r_ovf <= 1'b1;
            end

            if (r_state == ST_WSUM) begin
                r_wstep <= r_wstep + 1'b1;
            end else begin
                r_wstep <= '0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_sum       <= '0;
                r_count     <= '0;
                r_ovf       <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sample windows, accumulator and result word
    always_ff @(posedge i_clk) begin
        if (take_sample) begin
            if (r_count < END_CNT) begin
                r_head[r_count[1:0]] <= i_in_data.sample;
            end
            for (int i = END_POINTS - 1; i > 0; i--) begin
                r_tail[i] <= r_tail[i-1];
            end
            r_tail[0] <= i_in_data.sample;
        end
        if (r_state == ST_WSUM) begin
            r_acc <= acc_base + operand;
        end
        if (out_load) begin
            r_out_data.integral       <= sc_rsp.value;
            r_out_data.saturated      <= sc_rsp.sat;
            r_out_data.count_overflow <= r_ovf;
            r_out_data.points_used    <= POINTS_W'(r_count);
        end
    end

    assign sc_req.start = sc_start;
    assign sc_req.wsum  = {{(MAG_W-WW){r_acc[WW-1]}}, r_acc};
    assign sc_req.step  = r_step_size;

    esi_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sc_req),
        .o_rsp   (sc_rsp)
    );

    assign pready      = 1'b1;
    assign prdata      = (paddr[PADDR_W-1] == REG_IDX_STEP_SIZE) ? r_step_size : '0;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("sample count beyond MAX_POINTS");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == MAX_CNT))
        else $error("overflow flagged on a run that is not full");

    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WSUM) |-> (r_count != '0))
        else $error("end-of-run pass on an empty run");

    a_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sc_rsp.done |-> (r_state == ST_WAIT))
        else $error("scale result arrived outside the wait state");

endmodule

// ===== rtl/esi_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esi_scale - step multiply, round and divide by 48 * 2^16
// Sign/magnitude multiply in two 32x32 passes, then divide by 3 one 16-bit
// digit per cycle through a reciprocal multiply.
// ----------------------------------------------------------------------------
module esi_scale (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esi_pkg::t_sc_req  i_req,
    output esi_pkg::t_sc_rsp  o_rsp
);
    import esi_pkg::*;

    localparam int CNT_W = $clog2(DIV_DIGITS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_DIGITS - 1);

    t_sc_state                  r_state, n_state;
    logic                       r_neg;
    logic [MAG_W-1:0]           r_mw;
    logic [STEP_W-1:0]          r_ms;
    logic [2*LIMB_W-1:0]        r_prod;
    logic [PROD_W-1:0]          r_acc;
    logic [QUO_W-1:0]           r_div;
    logic [1:0]                 r_rem;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_done;
    logic                       r_sat;
    logic signed [INTEG_W-1:0]  r_val;

    logic [LIMB_W-1:0]          mul_a;
    logic [2*LIMB_W-1:0]        mul_p;
    logic [PROD_W-1:0]          add_a, add_b, add_sum;
    logic [CUR_W-1:0]           div_cur;
    logic [CUR_W+RECIP_W-1:0]   div_prod;
    logic [DIGIT_W-1:0]         div_q;
    logic [CUR_W-1:0]           div_q3;
    logic [1:0]                 div_rem;
    logic [INTEG_W-1:0]         limit, mag;
    logic                       over;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SC_IDLE:   if (i_req.start) n_state = SC_MUL_LO;
            SC_MUL_LO: n_state = SC_MUL_HI;
            SC_MUL_HI: n_state = SC_ACC;
            SC_ACC:    n_state = SC_DIV;
            SC_DIV:    if (r_cnt == DIV_LAST) n_state = SC_SAT;
            SC_SAT:    n_state = SC_IDLE;
            default:   n_state = SC_IDLE;
        endcase
    end

    // datapath selects for the shared multiplier, adder and divide step
    always_comb begin
        mul_a = (r_state == SC_MUL_HI) ? r_mw[MAG_W-1:LIMB_W] : r_mw[LIMB_W-1:0];
        mul_p = mul_a * r_ms;

        if (r_state == SC_ACC) begin
            add_a = r_acc;
            add_b = {r_prod, {LIMB_W{1'b0}}};
        end else begin
            add_a = ROUND_BIAS;
            add_b = {{LIMB_W{1'b0}}, r_prod};
        end
        add_sum = add_a + add_b;

        // top digit with the running remainder, divided by 3
        div_cur  = {r_rem, r_div[QUO_W-1 -: DIGIT_W]};
        div_prod = div_cur * RECIP_3;
        div_q    = div_prod[RECIP_SHIFT +: DIGIT_W];
        div_q3   = {1'b0, div_q, 1'b0} + {2'b00, div_q};
        div_rem  = 2'(div_cur - div_q3);

        limit = r_neg ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
        over  = (|r_div[QUO_W-1:INTEG_W]) || (r_div[INTEG_W-1:0] > limit);
        mag   = over ? limit : r_div[INTEG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == SC_SAT);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SC_IDLE: begin
                r_neg <= i_req.wsum[MAG_W-1] ^ i_req.step[STEP_W-1];
                r_mw  <= i_req.wsum[MAG_W-1] ? MAG_W'(-i_req.wsum) : MAG_W'(i_req.wsum);
                r_ms  <= i_req.step[STEP_W-1] ? STEP_W'(-i_req.step) : STEP_W'(i_req.step);
            end
            SC_MUL_LO: begin
                r_prod <= mul_p;
            end
            SC_MUL_HI: begin
                r_prod <= mul_p;
                r_acc  <= add_sum;
            end
            SC_ACC: begin
                r_div <= QUO_W'(add_sum[PROD_W-1:FRAC_SHIFT]);
                r_rem <= 2'd0;
                r_cnt <= '0;
            end
            SC_DIV: begin
                r_div <= {r_div[QUO_W-DIGIT_W-1:0], div_q};
                r_rem <= div_rem;
                r_cnt <= r_cnt + 1'b1;
            end
            SC_SAT: begin
                r_sat <= over;
                r_val <= r_neg ? INTEG_W'(-mag) : mag;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.sat   = r_sat;
    assign o_rsp.value = r_val;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == SC_IDLE))
        else $error("scale unit started while busy");

    a_rem_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SC_DIV) |-> (r_rem < DIVISOR))
        else $error("divide remainder out of range");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for extended_simpson_integrator
// Streams runs of Q16.16 sample words, predicts each run's integral with an
// independent fixed-point model, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_top;
    import esi_pkg::*;

    localparam int RUN_MAX       = 65536;       // MAX_POINTS of the block
    localparam int RAND_WORDS    = 195;         // minimum sample words per random phase
    localparam int SETTLE_CYCLES = 120;         // longer than the end-of-run pass
    localparam int HOLD_CYCLES   = 400;         // long receiver hold-off
    localparam longint TIMEOUT_NS = 2_000_000;  // watchdog on the whole test

    // integral = w * step / (48 * 2^16), rounded half away from zero
    localparam logic [127:0] SCALE_DIV  = 128'd3145728;
    localparam logic [127:0] SCALE_HALF = 128'd1572864;

    localparam logic [PADDR_W-1:0] STEP_ADDR = PADDR_W'(4 * REG_IDX_STEP_SIZE);
    localparam logic signed [STEP_W-1:0] STEP_ONE = 32'sd65536;
    localparam logic signed [SAMPLE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] Q_MIN = 32'sh8000_0000;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_data;

    always #1 i_clk = ~i_clk;

    extended_simpson_integrator #(
        .MAX_POINTS (RUN_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_in_item  sample_q[$];     // sample words waiting to be sent
    t_out_item integral_q[$];   // predicted result words, oldest first
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        recv_hold = 0;   // cycles left in a forced receiver hold-off
    int        hold_reqs = 0;   // hold-offs asked for by the main sequence
    int        hold_seen = 0;   // hold-offs started by the receiver
    int        mismatches = 0;

    // predictor copy of the block's state and its one register
    logic signed [STEP_W-1:0] step_q = STEP_ONE;
    longint                   acc_sum = 0;
    int                       acc_count = 0;
    bit                       acc_overflow = 1'b0;
    longint                   head_win[END_POINTS];
    longint                   tail_win[END_POINTS];  // entry 0 newest

    // ------------------------------------------------------------------------
    // predictor: folds one accepted sample word into the run; on the last
    // word of a run it returns 1 with the expected result word.
    // Weighted sum is kept as 48x the true sum so every weight is an integer.
    // ------------------------------------------------------------------------
    function automatic bit simpson_accumulate(input t_in_item word, output t_out_item res);
        longint       s;
        longint       w;
        bit [127:0]   mag_w;
        bit [127:0]   mag_step;
        bit [127:0]   quot;
        bit [127:0]   limit;
        bit           neg;
        int           k;
        res = '0;
        s = longint'($signed(word.sample));
        if (acc_count < RUN_MAX) begin
            acc_sum += s;
            if (acc_count < END_POINTS) begin
                head_win[acc_count] = s;
            end
            for (k = END_POINTS - 1; k > 0; k--) begin
                tail_win[k] = tail_win[k-1];
            end
            tail_win[0] = s;
            acc_count++;
        end else begin
            // past the point limit: word is dropped, only the flag remembers it
            acc_overflow = 1'b1;
        end
        if (!word.last) begin
            return 1'b0;
        end

        w = 48 * acc_sum;
        if (acc_count >= LONG_RUN_MIN) begin
            // end weights 17,59,43,49 (/48) expressed as offsets from 48
            w += -31 * (head_win[0] + tail_win[0]) + 11 * (head_win[1] + tail_win[1])
                 - 5 * (head_win[2] + tail_win[2]) + (head_win[3] + tail_win[3]);
        end else if (acc_count >= SHORT_RUN_MIN) begin
            // trapezoid ends: weight 1/2 = 24/48
            w -= 24 * (head_win[0] + tail_win[0]);
        end

        // sign-magnitude scale, round half up on the magnitude, then clip
        neg      = (w < 0) != (step_q < 0);
        mag_w    = (w < 0) ? 128'(-w) : 128'(w);
        mag_step = (step_q < 0) ? 128'(-longint'(step_q)) : 128'(longint'(step_q));
        quot     = (mag_w * mag_step + SCALE_HALF) / SCALE_DIV;
        limit    = neg ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
        res.saturated = (quot > limit);
        if (res.saturated) begin
            quot = limit;
        end
        res.integral       = neg ? -quot[63:0] : quot[63:0];
        res.count_overflow = acc_overflow;
        res.points_used    = POINTS_W'(acc_count);

        acc_sum      = 0;
        acc_count    = 0;
        acc_overflow = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // sender: offers the next queued word, holds it until accepted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (sample_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                i_in_data  <= sample_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // accepted sample words drive the predictor
    always @(posedge i_clk) begin
        t_out_item res;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (simpson_accumulate(i_in_data, res)) begin
                integral_q.push_back(res);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus a forced hold-off counted down here
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            i_out_ready <= 1'b0;
            hold_seen   <= hold_reqs;
            recv_hold   <= HOLD_CYCLES - 1;
        end else if (recv_hold > 0) begin
            i_out_ready <= 1'b0;
            recv_hold   <= recv_hold - 1;
        end else begin
            i_out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    function automatic void log_mismatch(input string why, input t_out_item want,
                                         input t_out_item got);
        if (mismatches < 10) begin
            $display("%0t %s: expected integral=%0d sat=%0b ovf=%0b points=%0d",
                     $time, why, want.integral, want.saturated, want.count_overflow,
                     want.points_used);
            $display("%0t %s:   actual integral=%0d sat=%0b ovf=%0b points=%0d",
                     $time, why, got.integral, got.saturated, got.count_overflow,
                     got.points_used);
        end
        mismatches++;
    endfunction

    // result checker: every accepted result word against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (integral_q.size() == 0) begin
                log_mismatch("unexpected result word", '0, o_out_data);
            end else begin
                want = integral_q.pop_front();
                if (o_out_data.integral !== want.integral ||
                    o_out_data.saturated !== want.saturated ||
                    o_out_data.count_overflow !== want.count_overflow ||
                    o_out_data.points_used !== want.points_used) begin
                    log_mismatch("result mismatch", want, o_out_data);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_word(input logic signed [SAMPLE_W-1:0] s, input logic lst);
        t_in_item word;
        word.sample = s;
        word.last   = lst;
        sample_q.push_back(word);
    endfunction

    // mix of range ends, small values and full-range random bits
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9, 0))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return -32'sd1;
            4, 5:    return $signed(32'($urandom_range(262143, 0))) - 32'sd131072;
            default: return $urandom;
        endcase
    endfunction

    // one complete run; lengths weighted around the short/long boundaries
    function automatic int queue_run();
        int len;
        int n;
        case ($urandom_range(9, 0))
            0:       len = 1;
            1, 2, 3: len = $urandom_range(7, 2);
            4, 5, 6: len = $urandom_range(16, 8);
            default: len = $urandom_range(60, 17);
        endcase
        for (n = 0; n < len; n++) begin
            queue_word(pick_sample(), n == len - 1);
        end
        return len;
    endfunction

    // APB write: setup then access; register loads at the access edge
    task automatic write_step(input logic signed [STEP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STEP_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        step_q   = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding,
    // then let the end-of-run pass settle before touching the register
    task automatic wait_drained();
        while (sample_q.size() != 0 || i_in_valid || integral_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input logic signed [STEP_W-1:0] step, input int send_pct,
                                input int recv_pct, input bit pressure);
        int words;
        write_step(step);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        words = 0;
        while (words < RAND_WORDS) begin
            words += queue_run();
        end
        if (pressure) begin
            // output held off while words keep coming: result register fills,
            // next end-of-run pass blocks, input ready drops
            @(negedge i_clk);
            hold_reqs++;
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed runs at step 1.0, no idling
        write_step(STEP_ONE);
        queue_word(Q_MAX, 1'b1);                    // single point, top of range
        queue_word(Q_MIN, 1'b1);                    // single point, bottom of range
        queue_word(Q_MAX, 1'b0);                    // two points: trapezoid ends
        queue_word(Q_MIN, 1'b1);
        for (n = 0; n < 3; n++) queue_word(Q_MIN, n == 2);
        for (n = 0; n < 7; n++) begin               // longest short run
            queue_word(32'sd65536 * (n + 1), n == 6);
        end
        for (n = 0; n < 8; n++) begin               // shortest long run: each end weight
            queue_word((n % 2) ? Q_MAX : -32'sd65536 * (n + 3), n == 7);
        end
        queue_word('0, 1'b1);
        wait_drained();

        // random runs across register settings and idling patterns
        random_phase(Q_MAX, 0, 0, 1'b1);
        random_phase(Q_MIN, 87, 0, 1'b0);
        random_phase($urandom, 0, 87, 1'b0);
        random_phase('0, 9, 9, 1'b0);
        random_phase(32'sh0000_8000, 0, 0, 1'b0);
        random_phase(-32'sd65536 * 3, 87, 0, 1'b0);

        // a long run and a single-point run at the most negative step to see the counters start clean
        write_step(Q_MIN);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (n = 0; n < 9; n++) queue_word(pick_sample(), n == 8);
        queue_word(Q_MAX, 1'b1);
        wait_drained();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
